// File: rtl/ulcr_pkg.sv
// ----------------------------------------------------------------------------
// ulcr_pkg
// Shared types, constants and text tables of the UART line command responder.
// ----------------------------------------------------------------------------
package ulcr_pkg;

    // Default sizes
    localparam int DEF_LINE_DEPTH  = 32;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Line terminators, zero byte and command letters
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_LO_O = 8'h6F;  // 'o'
    localparam logic [7:0] CHAR_LO_F = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_LO_N = 8'h6E;  // 'n'

    // Fixed response texts
    localparam int MSG_OFF_LEN  = 9;
    localparam int MSG_ON_LEN   = 8;
    localparam int MSG_ECHO_LEN = 6;

    localparam logic [7:0] MSG_OFF [MSG_OFF_LEN] =
        '{8'h4C, 8'h45, 8'h44, 8'h20, 8'h6F, 8'h66, 8'h66, 8'h0D, 8'h0A};
    localparam logic [7:0] MSG_ON [MSG_ON_LEN] =
        '{8'h4C, 8'h45, 8'h44, 8'h20, 8'h6F, 8'h6E, 8'h0D, 8'h0A};
    localparam logic [7:0] MSG_ECHO [MSG_ECHO_LEN] =
        '{8'h45, 8'h63, 8'h68, 8'h6F, 8'h3A, 8'h20};

    // Kind of response
    typedef enum logic [1:0] {
        K_OFF  = 2'd0,
        K_ON   = 2'd1,
        K_ECHO = 2'd2
    } t_kind;

    // One classified item in the queue
    typedef struct packed {
        logic       eol;
        logic [7:0] data;
    } t_item;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Length of the fixed text of a response kind
    function automatic logic [3:0] f_msg_len(t_kind k);
        logic [3:0] len;
        unique case (k)
            K_OFF:   len = 4'(MSG_OFF_LEN);
            K_ON:    len = 4'(MSG_ON_LEN);
            K_ECHO:  len = 4'(MSG_ECHO_LEN);
            default: len = 4'(MSG_ECHO_LEN);
        endcase
        return len;
    endfunction

    // Character of the fixed text at index i
    function automatic logic [7:0] f_msg_char(t_kind k, logic [3:0] i);
        logic [7:0] c;
        c = CHAR_NUL;
        unique case (k)
            K_OFF:   if (int'(i) < MSG_OFF_LEN)  c = MSG_OFF[i];
            K_ON:    if (int'(i) < MSG_ON_LEN)   c = MSG_ON[i[2:0]];
            K_ECHO:  if (int'(i) < MSG_ECHO_LEN) c = MSG_ECHO[i[2:0]];
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/uart_line_command_responder.sv
// ----------------------------------------------------------------------------
// uart_line_command_responder
// Line-based command responder: collects received bytes into lines and
// answers "off", "on" or anything else with an LED message or an echo.
// ----------------------------------------------------------------------------
// Each received byte is one input transfer; ordinary bytes are stored and
// give no output, CR or LF closes the line and starts the response, which
// leaves as one character per output transfer with tlast on its final one
// and tuser carrying the LED level after that line. A byte passes the
// combinational front end into the queue and is stored by the back end
// once popped. A response holds 9 or 8 characters for the LED commands and
// 8 plus the line length for an echo, up to LINE_DEPTH + 7; the single
// output register takes the next one when empty or when its character is
// taken. During a response the queue accepts up to QUEUE_DEPTH further bytes.
// ----------------------------------------------------------------------------
module uart_line_command_responder
    import ulcr_pkg::*;
#(
    parameter int LINE_DEPTH  = DEF_LINE_DEPTH,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] tx_byte
    output logic       o_m_axis_tlast,   // last
    output logic [0:0] o_m_axis_tuser    // [0] led_level
);

    t_q_status q_status;
    t_item     push_item;
    t_item     head_item;
    logic      push;
    logic      pop;

    ulcr_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_item          (push_item)
    );

    ulcr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (push_item),
        .i_pop      (pop),
        .o_item     (head_item),
        .o_q_status (q_status)
    );

    ulcr_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (head_item),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// File: rtl/ulcr_front.sv
// ----------------------------------------------------------------------------
// ulcr_front
// Accepts received bytes and tags each one as line end or ordinary byte.
// ----------------------------------------------------------------------------
module ulcr_front
    import ulcr_pkg::*;
(
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_item      o_item
);

    // Take a byte whenever the queue has room
    assign o_s_axis_tready = !i_q_status.full;
    assign o_push          = i_s_axis_tvalid && !i_q_status.full;

    // Classify: CR or LF closes the line
    always_comb begin
        o_item.data = i_s_axis_tdata;
        o_item.eol  = (i_s_axis_tdata == CHAR_CR) || (i_s_axis_tdata == CHAR_LF);
    end

endmodule

// File: rtl/ulcr_queue.sv
// ----------------------------------------------------------------------------
// ulcr_queue
// Short first-word-fall-through queue between front and back end.
// ----------------------------------------------------------------------------
module ulcr_queue
    import ulcr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_q_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign do_push = i_push && (int'(r_count) < QUEUE_DEPTH);
    assign do_pop  = i_pop && (r_count != '0);

    assign o_item           = r_mem[r_rd_ptr];
    assign o_q_status.full  = (int'(r_count) == QUEUE_DEPTH);
    assign o_q_status.empty = (r_count == '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/ulcr_back.sv
// ----------------------------------------------------------------------------
// ulcr_back
// Stores line bytes, decides the command at line end and sends the response
// one character per transfer through an output register.
// ----------------------------------------------------------------------------
module ulcr_back
    import ulcr_pkg::*;
#(
    parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] tx_byte
    output logic       o_m_axis_tlast,   // last
    output logic [0:0] o_m_axis_tuser    // [0] led_level
);

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int CNT_W  = (ADDR_W > 4) ? ADDR_W : 4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MSG  = 4'b0010,
        S_ECHO = 4'b0100,
        S_CRLF = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_idx, n_idx;
    t_kind              r_kind;
    logic               r_led;
    logic [ADDR_W-1:0]  r_resp_len;

    // Line store and its bookkeeping
    logic [7:0]         r_mem [LINE_DEPTH];
    logic [7:0]         r_rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  r_fill;
    logic [ADDR_W-1:0]  r_len;    // bytes before first zero of current line
    logic               r_zero;   // zero byte seen in current line
    logic               r_c0_o, r_c1_f, r_c1_n, r_c2_f;

    // Output register
    logic               r_out_valid;
    logic [7:0]         r_out_data;
    logic               r_out_last;
    logic               r_out_led;
    logic               can_load;
    logic               load;
    logic [7:0]         n_char;
    logic               n_last;

    // Line-end decision
    logic [ADDR_W-1:0]  eff_len;
    logic               is_off;
    logic               is_on;
    logic               pop_eol;
    logic               pop_byte;

    assign can_load = !r_out_valid || i_m_axis_tready;
    assign pop_eol  = o_pop && i_item.eol;
    assign pop_byte = o_pop && !i_item.eol;

    // A line whose fill index has wrapped to zero, or an empty line, has length zero
    assign eff_len = (r_fill == '0) ? '0 : r_len;
    assign is_off  = (eff_len == ADDR_W'(3)) && r_c0_o && r_c1_f && r_c2_f;
    assign is_on   = (eff_len == ADDR_W'(2)) && r_c0_o && r_c1_n;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        load    = 1'b0;
        n_char  = CHAR_NUL;
        n_last  = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    if (i_item.eol) begin
                        n_state = S_MSG;
                        n_idx   = '0;
                    end
                end
            end
            S_MSG: begin
                if (can_load) begin
                    load   = 1'b1;
                    n_char = f_msg_char(r_kind, r_idx[3:0]);
                    if (r_idx[3:0] == f_msg_len(r_kind) - 4'd1) begin
                        n_idx = '0;
                        if (r_kind != K_ECHO) begin
                            n_last  = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_resp_len == '0) begin
                            n_state = S_CRLF;
                        end else begin
                            n_state = S_ECHO;
                        end
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            S_ECHO: begin
                if (can_load) begin
                    load   = 1'b1;
                    n_char = r_rd_data;
                    if (r_idx[ADDR_W-1:0] == r_resp_len - ADDR_W'(1)) begin
                        n_idx   = '0;
                        n_state = S_CRLF;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            S_CRLF: begin
                if (can_load) begin
                    load = 1'b1;
                    if (r_idx == '0) begin
                        n_char = CHAR_CR;
                        n_idx  = CNT_W'(1);
                    end else begin
                        n_char  = CHAR_LF;
                        n_last  = 1'b1;
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    // Prefetch the entry the echo phase needs next
    assign rd_addr = (int'(n_idx) < LINE_DEPTH) ? n_idx[ADDR_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (pop_byte) begin
            r_mem[r_fill] <= i_item.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Running length and command letters, tracked as bytes arrive
    always_ff @(posedge i_clk) begin
        if (pop_byte) begin
            if (r_fill == '0) begin
                r_zero <= (i_item.data == CHAR_NUL);
                r_len  <= (i_item.data == CHAR_NUL) ? '0 : ADDR_W'(1);
                r_c0_o <= (i_item.data == CHAR_LO_O);
            end else if (!r_zero) begin
                if (i_item.data == CHAR_NUL) begin
                    r_zero <= 1'b1;
                end else begin
                    r_len <= r_len + ADDR_W'(1);
                end
            end
            if (r_fill == ADDR_W'(1)) begin
                r_c1_f <= (i_item.data == CHAR_LO_F);
                r_c1_n <= (i_item.data == CHAR_LO_N);
            end
            if (r_fill == ADDR_W'(2)) begin
                r_c2_f <= (i_item.data == CHAR_LO_F);
            end
        end
    end

    // Response setup at line end
    always_ff @(posedge i_clk) begin
        if (pop_eol) begin
            r_resp_len <= eff_len;
            if (is_off) begin
                r_kind <= K_OFF;
            end else if (is_on) begin
                r_kind <= K_ON;
            end else begin
                r_kind <= K_ECHO;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_fill      <= '0;
            r_led       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (pop_byte) begin
                r_fill <= (int'(r_fill) == LINE_DEPTH - 1) ? '0 : r_fill + ADDR_W'(1);
            end else if (pop_eol) begin
                r_fill <= '0;
            end
            if (pop_eol && is_off) begin
                r_led <= 1'b0;
            end else if (pop_eol && is_on) begin
                r_led <= 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload; the LED level travels with its character
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= n_char;
            r_out_last <= n_last;
            r_out_led  <= r_led;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_led;

`ifndef SYNTHESIS
    a_last_ends_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_last) |=> (r_state == S_IDLE))
        else $error("response did not end after its last character");

    a_echo_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ECHO) |-> (r_idx[ADDR_W-1:0] < r_resp_len))
        else $error("echo index beyond line length");

    a_len_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> (r_len <= r_fill))
        else $error("line length exceeds fill index");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_eol |=> !o_pop)
        else $error("queue popped while a response is starting");
`endif

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UART line command responder: drives byte
// streams (commands, echo lines, zero bytes, store wrap, random noise) with
// random gaps and back-pressure, predicts each response character and
// compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import ulcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH  = DEF_LINE_DEPTH;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int DRAIN_WAIT  = 60;

    // One predicted response character
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       led;
    } t_reply_char;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       m_ready = 1'b0;

    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic [0:0] o_m_axis_tuser;

    // Predictor state
    logic [7:0]  line_mem [LINE_DEPTH];
    int          fill_pos  = 0;
    logic        led_model = 1'b1;
    logic [7:0]  reply_text [$];
    t_reply_char expected_chars [$];

    // Run control and bookkeeping
    logic tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;
    logic closing    = 1'b0;
    int   hold_left  = 0;
    int   rx_gap     = 0;
    int   bytes_sent = 0;
    int   lines_done = 0;
    int   chars_seen = 0;
    int   errors     = 0;
    int   cycles     = 0;

    uart_line_command_responder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),          // [7:0] rx_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [7:0] tx_byte
        .o_m_axis_tlast  (o_m_axis_tlast),  // last
        .o_m_axis_tuser  (o_m_axis_tuser)   // [0] led_level
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("uart_line_command_responder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            reply_text.push_back(s[i]);
    endfunction

    function automatic logic line_is(string w, int n);
        if (n != w.len())
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (line_mem[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Update the line state with one received byte; queue the reply on a line end
    task automatic predict_rx_byte(input logic [7:0] c);
        int          n;
        t_reply_char r;
        if (c != CHAR_CR && c != CHAR_LF) begin
            line_mem[fill_pos] = c;
            fill_pos = (fill_pos + 1) % LINE_DEPTH;
            return;
        end
        // line runs up to the fill index or the first zero byte
        n = 0;
        while (n < fill_pos && line_mem[n] != CHAR_NUL)
            n++;
        fill_pos = 0;
        reply_text.delete();
        if (line_is("off", n)) begin
            led_model = 1'b0;
            add_text("LED off");
        end else if (line_is("on", n)) begin
            led_model = 1'b1;
            add_text("LED on");
        end else begin
            add_text("Echo: ");
            for (int i = 0; i < n; i++)
                reply_text.push_back(line_mem[i]);
        end
        reply_text.push_back(CHAR_CR);
        reply_text.push_back(CHAR_LF);
        foreach (reply_text[k]) begin
            r.ch   = reply_text[k];
            r.last = (k == reply_text.size() - 1);
            r.led  = led_model;
            expected_chars.push_back(r);
        end
        lines_done++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready pattern and checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 10) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Sample at the falling edge; the transfer happens at the next rising edge
    always @(negedge i_clk) begin : check_tx
        t_reply_char want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual %h last %b led %b",
                         $time, o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser[0]);
            end else begin
                want = expected_chars.pop_front();
                if (o_m_axis_tdata !== want.ch) begin
                    errors++;
                    $display("%0t: tx_byte expected %h actual %h",
                             $time, want.ch, o_m_axis_tdata);
                end
                if (o_m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, o_m_axis_tlast);
                end
                if (o_m_axis_tuser[0] !== want.led) begin
                    errors++;
                    $display("%0t: led_level expected %b actual %b",
                             $time, want.led, o_m_axis_tuser[0]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one byte and wait for its transfer; returns at that rising edge
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(negedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        predict_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_printable(input int n);
        repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    // CR, LF, or CR LF (the LF then closes an empty line)
    task automatic send_line_end();
        case ($urandom_range(0, 3))
            0: send_byte(CHAR_CR);
            1: send_byte(CHAR_LF);
            2: begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            default: send_byte(CHAR_LF);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Both commands and the empty line
    task automatic test_commands();
        send_text("off");
        send_byte(CHAR_CR);
        send_text("on");
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
    endtask

    // Extreme byte values echoed back
    task automatic test_byte_extremes();
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(CHAR_LF);
    endtask

    // Zero byte cuts the line for both compare and echo
    task automatic test_zero_byte();
        send_text("of");
        send_byte(CHAR_CR);
        send_text("on");
        send_byte(CHAR_NUL);
        send_text("x");
        send_byte(CHAR_CR);
        send_byte(CHAR_NUL);
        send_text("on");
        send_byte(CHAR_LF);
    endtask

    // Lines just below, at and past the store depth
    task automatic test_line_wrap();
        send_printable(LINE_DEPTH - 1);
        send_byte(CHAR_CR);
        send_printable(LINE_DEPTH);      // index wraps to 0: empty echo
        send_byte(CHAR_LF);
        send_printable(LINE_DEPTH + 2);  // only the two wrapped bytes remain
        send_byte(CHAR_CR);
    endtask

    // Receiver stalls long while lines keep coming, so the input backs up
    task automatic test_backpressure();
        hold_left = 300;
        repeat (6) begin
            send_text("ping");
            send_byte(CHAR_CR);
        end
    endtask

    // Mostly well-formed lines with random content, some noise
    task automatic test_random_lines(input int target);
        int kind;
        while (bytes_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                send_text("on");
            end else if (kind < 30) begin
                send_text("off");
            end else if (kind < 42) begin
                case ($urandom_range(0, 5))
                    0: send_text("o");
                    1: send_text("of");
                    2: send_text("onn");
                    3: send_text("offf");
                    4: send_text("On");
                    default: send_text("oof");
                endcase
            end else if (kind < 72) begin
                send_printable($urandom_range(0, 12));
            end else if (kind < 77) begin
                send_printable($urandom_range(LINE_DEPTH - 4, LINE_DEPTH + 8));
            end else if (kind < 88) begin
                if ($urandom_range(0, 1))
                    send_text($urandom_range(0, 1) ? "on" : "off");
                else
                    send_printable($urandom_range(0, 5));
                send_byte(CHAR_NUL);
                send_printable($urandom_range(0, 4));
            end else begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end
            send_line_end();
            // occasional stretches without idling on either side
            if (!closing && $urandom_range(0, 19) == 0) begin
                tx_idle_en = ~tx_idle_en;
                rx_idle_en = ~rx_idle_en;
            end
        end
    endtask

    initial begin
        foreach (line_mem[i])
            line_mem[i] = 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_byte_extremes();
        test_zero_byte();
        test_line_wrap();
        test_backpressure();
        test_random_lines(320);

        // closing stretch with no idling
        closing    = 1'b1;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_lines(380);
        s_valid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d bytes closing %0d lines; compared %0d response characters.",
                 bytes_sent, lines_done, chars_seen);
        $display("Covered both commands, echoes, zero bytes, store wrap and back-pressure.");
        if (errors == 0 && expected_chars.size() == 0) begin
            $display("uart_line_command_responder: match");
        end else begin
            $display("uart_line_command_responder: mismatch");
        end
        $finish;
    end

endmodule
